// ===== src/mjq_pkg.sv =====
package mjq_pkg;

    localparam int IN_W     = 32;
    localparam int DUR_W    = 24;
    localparam int COEF_W   = 48;
    localparam int OUT_FRAC = 24;
    // Numerator width covers all combinations of the difference terms.
    localparam int NUM_W    = 100;
    localparam int P1_W     = 60;
    localparam int FRONT_LAT = 7;
    localparam int DIV_LAT   = COEF_W + 3;
    localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DUR = 2'd1,
        STATUS_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_zero;
        logic signed [COEF_W-1:0] coef_one;
        logic signed [COEF_W-1:0] coef_two;
        logic                     zero_dur;
    } side_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_zero;
        logic signed [COEF_W-1:0] coef_one;
        logic signed [COEF_W-1:0] coef_two;
        logic signed [COEF_W-1:0] coef_three;
        logic signed [COEF_W-1:0] coef_four;
        logic signed [COEF_W-1:0] coef_five;
        status_t                  status;
    } res_t;

endpackage

// ===== src/mjq_front.sv =====
module mjq_front #(
    parameter int FRAC = 16
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [mjq_pkg::IN_W-1:0]    start_position,
    input  logic signed [mjq_pkg::IN_W-1:0]    start_velocity,
    input  logic signed [mjq_pkg::IN_W-1:0]    start_accel,
    input  logic signed [mjq_pkg::IN_W-1:0]    end_position,
    input  logic signed [mjq_pkg::IN_W-1:0]    end_velocity,
    input  logic signed [mjq_pkg::IN_W-1:0]    end_accel,
    input  logic        [mjq_pkg::DUR_W-1:0]   duration,
    output logic signed [mjq_pkg::NUM_W-1:0]   num3,
    output logic signed [mjq_pkg::NUM_W-1:0]   num4,
    output logic signed [mjq_pkg::NUM_W-1:0]   num5,
    output logic        [72:0]                 dvs3,
    output logic        [96:0]                 dvs4,
    output logic        [120:0]                dvs5
);
    localparam int NW = mjq_pkg::NUM_W;
    localparam int PW = mjq_pkg::P1_W;

    // stage 1: differences and first products
    logic signed [32:0] dx1_reg, dvl1_reg, p2_1_reg;
    logic signed [56:0] v0d1_reg, a0d1_reg;
    logic        [47:0] d2_1_reg;
    logic        [23:0] d1_reg;
    logic signed [24:0] dur_s;

    assign dur_s = $signed({1'b0, duration});

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg  <= 33'(end_position) - 33'(start_position);
            dvl1_reg <= 33'(end_velocity) - 33'(start_velocity);
            p2_1_reg <= 33'(end_accel) - 33'(start_accel);
            v0d1_reg <= 57'(start_velocity) * 57'(dur_s);
            a0d1_reg <= 57'(start_accel) * 57'(dur_s);
            d2_1_reg <= 48'(duration) * 48'(duration);
            d1_reg   <= duration;
        end
    end

    // stage 2
    logic        [51:0] a0dd_lo_reg;
    logic signed [53:0] a0dd_hi_reg;
    logic        [47:0] d3_lo_reg, d3_hi_reg;
    logic signed [PW-1:0] p1_2_reg;
    logic signed [NW-1:0] q0_2_reg;
    logic signed [32:0] p2_2_reg;
    logic        [47:0] d2_2_reg;
    logic        [23:0] d2_reg;
    logic signed [28:0] a0h;
    logic signed [24:0] d1_s;

    assign a0h  = a0d1_reg[56:28];
    assign d1_s = $signed({1'b0, d1_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            a0dd_lo_reg <= 52'(a0d1_reg[27:0]) * 52'(d1_reg);
            a0dd_hi_reg <= 54'(a0h) * 54'(d1_s);
            d3_lo_reg   <= 48'(d2_1_reg[23:0]) * 48'(d1_reg);
            d3_hi_reg   <= 48'(d2_1_reg[47:24]) * 48'(d1_reg);
            p1_2_reg    <= (PW'(dvl1_reg) <<< FRAC) - PW'(a0d1_reg);
            q0_2_reg    <= (NW'(dx1_reg) <<< (2 * FRAC + 1)) - (NW'(v0d1_reg) <<< (FRAC + 1));
            p2_2_reg    <= p2_1_reg;
            d2_2_reg    <= d2_1_reg;
            d2_reg      <= d1_reg;
        end
    end

    // stage 3
    logic signed [NW-1:0] p0_3_reg;
    logic        [53:0] dp1_lo_reg;
    logic signed [54:0] dp1_hi_reg;
    logic signed [57:0] pp_lo_reg, pp_hi_reg;
    logic        [71:0] d3_3_reg;
    logic        [23:0] d3_reg;
    logic signed [29:0] p1h;
    logic signed [24:0] d2_s;
    logic signed [24:0] d2l_s, d2h_s;

    assign p1h   = p1_2_reg[PW-1:30];
    assign d2_s  = $signed({1'b0, d2_reg});
    assign d2l_s = $signed({1'b0, d2_2_reg[23:0]});
    assign d2h_s = $signed({1'b0, d2_2_reg[47:24]});

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_3_reg   <= q0_2_reg - ((NW'(a0dd_hi_reg) <<< 28) + NW'(a0dd_lo_reg));
            dp1_lo_reg <= 54'(p1_2_reg[29:0]) * 54'(d2_reg);
            dp1_hi_reg <= 55'(p1h) * 55'(d2_s);
            pp_lo_reg  <= 58'(p2_2_reg) * 58'(d2l_s);
            pp_hi_reg  <= 58'(p2_2_reg) * 58'(d2h_s);
            d3_3_reg   <= {d3_hi_reg, 24'b0} + 72'(d3_lo_reg);
            d3_reg     <= d2_reg;
        end
    end

    // stage 4
    logic signed [NW-1:0] p0_4_reg, dp1_4_reg, d2p2_4_reg;
    logic        [47:0] d4a_reg, d4b_reg, d4c_reg;
    logic        [71:0] d3_4_reg;
    logic        [23:0] d4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_4_reg   <= p0_3_reg;
            dp1_4_reg  <= (NW'(dp1_hi_reg) <<< 30) + NW'(dp1_lo_reg);
            d2p2_4_reg <= (NW'(pp_hi_reg) <<< 24) + NW'(pp_lo_reg);
            d4a_reg    <= 48'(d3_3_reg[23:0]) * 48'(d3_reg);
            d4b_reg    <= 48'(d3_3_reg[47:24]) * 48'(d3_reg);
            d4c_reg    <= 48'(d3_3_reg[71:48]) * 48'(d3_reg);
            d3_4_reg   <= d3_3_reg;
            d4_reg     <= d3_reg;
        end
    end

    // stage 5: scale by the closed-form constants
    logic signed [NW-1:0] e3_reg, e4_reg, e5_reg, d2p2_5_reg;
    logic        [95:0] d4_5_reg;
    logic        [71:0] d3_5_reg;
    logic        [23:0] d5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e3_reg     <= (p0_4_reg <<< 3) + (p0_4_reg <<< 1) - (dp1_4_reg <<< 3);
            e4_reg     <= (dp1_4_reg <<< 4) - (dp1_4_reg <<< 1) - (p0_4_reg <<< 4) + p0_4_reg;
            e5_reg     <= (p0_4_reg <<< 2) + (p0_4_reg <<< 1)
                          - (dp1_4_reg <<< 2) - (dp1_4_reg <<< 1);
            d2p2_5_reg <= d2p2_4_reg;
            d4_5_reg   <= 96'(d4a_reg) + 96'({d4b_reg, 24'b0}) + {d4c_reg, 48'b0};
            d3_5_reg   <= d3_4_reg;
            d5_reg     <= d4_reg;
        end
    end

    // stage 6
    logic signed [NW-1:0] n3_6_reg, n4_6_reg, n5_6_reg;
    logic        [47:0] d5a_reg, d5b_reg, d5c_reg, d5d_reg;
    logic        [95:0] d4_6_reg;
    logic        [71:0] d3_6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_6_reg <= e3_reg + d2p2_5_reg;
            n4_6_reg <= e4_reg - (d2p2_5_reg <<< 1);
            n5_6_reg <= e5_reg + d2p2_5_reg;
            d5a_reg  <= 48'(d4_5_reg[23:0]) * 48'(d5_reg);
            d5b_reg  <= 48'(d4_5_reg[47:24]) * 48'(d5_reg);
            d5c_reg  <= 48'(d4_5_reg[71:48]) * 48'(d5_reg);
            d5d_reg  <= 48'(d4_5_reg[95:72]) * 48'(d5_reg);
            d4_6_reg <= d4_5_reg;
            d3_6_reg <= d3_5_reg;
        end
    end

    // stage 7
    logic signed [NW-1:0] n3_7_reg, n4_7_reg, n5_7_reg;
    logic        [119:0] d5_7_reg;
    logic        [95:0]  d4_7_reg;
    logic        [71:0]  d3_7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_7_reg <= n3_6_reg;
            n4_7_reg <= n4_6_reg;
            n5_7_reg <= n5_6_reg;
            d5_7_reg <= 120'(d5a_reg) + 120'({d5b_reg, 24'b0}) + 120'({d5c_reg, 48'b0})
                        + {d5d_reg, 72'b0};
            d4_7_reg <= d4_6_reg;
            d3_7_reg <= d3_6_reg;
        end
    end

    assign num3 = n3_7_reg;
    assign num4 = n4_7_reg;
    assign num5 = n5_7_reg;
    assign dvs3 = {d3_7_reg, 1'b0};
    assign dvs4 = {d4_7_reg, 1'b0};
    assign dvs5 = {d5_7_reg, 1'b0};

endmodule

// ===== src/mjq_div.sv =====
module mjq_div #(
    parameter int NUM_W = 100,
    parameter int SHIFT = 24,
    parameter int DIV_W = 73
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [NUM_W-1:0]           num,
    input  logic        [DIV_W-1:0]           dvs,
    output logic signed [mjq_pkg::COEF_W-1:0] quot,
    output logic                              sat
);
    localparam int QB    = mjq_pkg::COEF_W;
    localparam int NW2   = NUM_W + SHIFT;
    localparam int TOP_W = NW2 - QB;
    localparam int CMP_W = (TOP_W > DIV_W) ? TOP_W : DIV_W;
    localparam logic [QB:0] LIM_POS = {2'b00, {(QB - 1){1'b1}}};
    localparam logic [QB:0] LIM_NEG = {2'b01, {(QB - 1){1'b0}}};

    // stage a: magnitude
    logic [NUM_W-1:0] mag_a_reg;
    logic             neg_a_reg;
    logic [DIV_W-1:0] dv_a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg <= num[NUM_W-1] ? (NUM_W'(0) - num) : num;
            neg_a_reg <= num[NUM_W-1];
            dv_a_reg  <= dvs;
        end
    end

    // stage b: overflow check, initial partial remainder
    logic [NW2-1:0]   wide;
    logic [CMP_W-1:0] top_x;
    logic             ovf_b;

    assign wide  = {mag_a_reg, {SHIFT{1'b0}}};
    assign top_x = CMP_W'(wide[NW2-1:QB]);
    assign ovf_b = top_x >= CMP_W'(dv_a_reg);

    logic [DIV_W-1:0] rem_reg [0:QB];
    logic [QB-1:0]    low_reg [0:QB];
    logic [QB-1:0]    q_reg   [0:QB];
    logic [DIV_W-1:0] dv_reg  [0:QB];
    logic             neg_reg [0:QB];
    logic             ovf_reg [0:QB];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= ovf_b ? '0 : top_x[DIV_W-1:0];
            low_reg[0] <= wide[QB-1:0];
            q_reg[0]   <= '0;
            dv_reg[0]  <= dv_a_reg;
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= ovf_b;
        end
    end

    // one quotient bit per stage
    for (genvar i = 0; i < QB; i++) begin : g_step
        logic [DIV_W:0] trial;
        logic           take;

        assign trial = {rem_reg[i], low_reg[i][QB-1]};
        assign take  = trial >= {1'b0, dv_reg[i]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= take ? DIV_W'(trial - {1'b0, dv_reg[i]})
                                     : trial[DIV_W-1:0];
                low_reg[i+1] <= {low_reg[i][QB-2:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][QB-2:0], take};
                dv_reg[i+1]  <= dv_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    // round half away from zero, clamp, restore sign
    logic          up;
    logic [QB:0]   qr, limit, mag_out;
    logic          sat_c;

    assign up      = {rem_reg[QB], 1'b0} >= {1'b0, dv_reg[QB]};
    assign qr      = {1'b0, q_reg[QB]} + (QB + 1)'(up);
    assign limit   = neg_reg[QB] ? LIM_NEG : LIM_POS;
    assign sat_c   = ovf_reg[QB] || (qr > limit);
    assign mag_out = sat_c ? limit : qr;

    logic signed [QB-1:0] quot_reg;
    logic                 sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= neg_reg[QB] ? QB'((QB + 1)'(0) - mag_out) : mag_out[QB-1:0];
            sat_reg  <= sat_c;
        end
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;

endmodule

// ===== src/min_jerk_quintic_solver.sv =====
// Minimum-jerk quintic solver, one axis per transaction.
// Input channel (s_valid/s_ready): start and end position, velocity and
// acceleration in signed fixed point with INPUT_FRAC_BITS fraction bits, and an
// unsigned duration with the same fraction bits.
// Result channel (m_valid/m_ready): six signed Q23.24 coefficients and a status
// (ok, zero duration, saturated cubic/quartic/quintic term).
// Throughput: one transaction per cycle while m_ready is high.
// Path: 59 register stages, the first of which loads at the accepting edge:
// seven form the numerators and duration powers with sliced multipliers, 51
// run three parallel restoring dividers, one quotient bit per stage, plus
// round and clamp, and one is the output register.
// Stalls: a two-entry output (result register plus skid register) parts the
// pipeline from the receiver; s_ready drops only once the skid entry is in use,
// and then the whole pipeline holds with no transaction lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; datapath registers
// keep whatever they held.
module min_jerk_quintic_solver #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [mjq_pkg::IN_W-1:0]     s_start_position,
    input  logic signed [mjq_pkg::IN_W-1:0]     s_start_velocity,
    input  logic signed [mjq_pkg::IN_W-1:0]     s_start_accel,
    input  logic signed [mjq_pkg::IN_W-1:0]     s_end_position,
    input  logic signed [mjq_pkg::IN_W-1:0]     s_end_velocity,
    input  logic signed [mjq_pkg::IN_W-1:0]     s_end_accel,
    input  logic        [mjq_pkg::DUR_W-1:0]    s_duration,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mjq_pkg::COEF_W-1:0]   m_coef_zero,
    output logic signed [mjq_pkg::COEF_W-1:0]   m_coef_one,
    output logic signed [mjq_pkg::COEF_W-1:0]   m_coef_two,
    output logic signed [mjq_pkg::COEF_W-1:0]   m_coef_three,
    output logic signed [mjq_pkg::COEF_W-1:0]   m_coef_four,
    output logic signed [mjq_pkg::COEF_W-1:0]   m_coef_five,
    output logic        [1:0]                   m_solve_status
);
    localparam int CW  = mjq_pkg::COEF_W;
    localparam int NW  = mjq_pkg::NUM_W;
    localparam int LAT = mjq_pkg::TOTAL_LAT;
    localparam int UPS = mjq_pkg::OUT_FRAC - INPUT_FRAC_BITS;

    logic en;
    logic skid_valid_reg;

    // The pipeline advances whenever the skid entry is free.
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Low-order coefficients: rescale to 24 fraction bits; halve start accel
    // with rounding away from zero.
    logic                 a_neg;
    logic [31:0]          a_mag;
    logic [CW:0]          a_m;
    logic [CW-1:0]        a_half;
    mjq_pkg::side_t       side_in;

    assign a_neg  = s_start_accel[31];
    assign a_mag  = a_neg ? (32'd0 - s_start_accel) : s_start_accel;
    assign a_m    = ((CW + 1)'(a_mag) << UPS) + (CW + 1)'(1);
    assign a_half = a_m[CW:1];

    always_comb begin
        side_in.coef_zero = CW'(s_start_position) <<< UPS;
        side_in.coef_one  = CW'(s_start_velocity) <<< UPS;
        side_in.coef_two  = a_neg ? (CW'(0) - a_half) : a_half;
        side_in.zero_dur  = (s_duration == '0);
    end

    // Valid bits and pass-through fields travel beside the datapath.
    logic           vld_reg  [0:LAT-1];
    mjq_pkg::side_t side_reg [0:LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 1; i < LAT; i++) begin : g_line
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Numerators and divisors.
    logic signed [NW-1:0] num3, num4, num5;
    logic [72:0]          dvs3;
    logic [96:0]          dvs4;
    logic [120:0]         dvs5;

    mjq_front #(
        .FRAC(INPUT_FRAC_BITS)
    ) u_front (
        .aclk          (aclk),
        .en            (en),
        .start_position(s_start_position),
        .start_velocity(s_start_velocity),
        .start_accel   (s_start_accel),
        .end_position  (s_end_position),
        .end_velocity  (s_end_velocity),
        .end_accel     (s_end_accel),
        .duration      (s_duration),
        .num3          (num3),
        .num4          (num4),
        .num5          (num5),
        .dvs3          (dvs3),
        .dvs4          (dvs4),
        .dvs5          (dvs5)
    );

    logic signed [CW-1:0] q3, q4, q5;
    logic                 sat3, sat4, sat5;

    mjq_div #(
        .NUM_W(NW), .SHIFT(mjq_pkg::OUT_FRAC), .DIV_W(73)
    ) u_div3 (
        .aclk(aclk), .en(en), .num(num3), .dvs(dvs3), .quot(q3), .sat(sat3)
    );

    mjq_div #(
        .NUM_W(NW), .SHIFT(mjq_pkg::OUT_FRAC + INPUT_FRAC_BITS), .DIV_W(97)
    ) u_div4 (
        .aclk(aclk), .en(en), .num(num4), .dvs(dvs4), .quot(q4), .sat(sat4)
    );

    mjq_div #(
        .NUM_W(NW), .SHIFT(mjq_pkg::OUT_FRAC + 2 * INPUT_FRAC_BITS), .DIV_W(121)
    ) u_div5 (
        .aclk(aclk), .en(en), .num(num5), .dvs(dvs5), .quot(q5), .sat(sat5)
    );

    // Assemble the finished result; a zero duration overrides the dividers.
    mjq_pkg::res_t  res_new;
    mjq_pkg::side_t side_last;

    assign side_last = side_reg[LAT-1];

    always_comb begin
        res_new.coef_zero = side_last.coef_zero;
        res_new.coef_one  = side_last.coef_one;
        res_new.coef_two  = side_last.coef_two;
        if (side_last.zero_dur) begin
            res_new.coef_three = '0;
            res_new.coef_four  = '0;
            res_new.coef_five  = '0;
            res_new.status     = mjq_pkg::STATUS_ZERO_DUR;
        end else begin
            res_new.coef_three = q3;
            res_new.coef_four  = q4;
            res_new.coef_five  = q5;
            res_new.status     = (sat3 || sat4 || sat5) ? mjq_pkg::STATUS_SAT
                                                        : mjq_pkg::STATUS_OK;
        end
    end

    // Output register plus skid entry.
    mjq_pkg::res_t out_reg, skid_reg;
    logic          out_valid_reg;
    logic          take_out, arrive;

    assign take_out = out_valid_reg && m_ready;
    assign arrive   = en && vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // drain the skid entry first
            if (take_out) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (arrive) begin
            if (!out_valid_reg || take_out) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take_out) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take_out) begin
                out_reg <= skid_reg;
            end
        end else if (arrive) begin
            if (!out_valid_reg || take_out) begin
                out_reg <= res_new;
            end else begin
                skid_reg <= res_new;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_coef_zero    = out_reg.coef_zero;
    assign m_coef_one     = out_reg.coef_one;
    assign m_coef_two     = out_reg.coef_two;
    assign m_coef_three   = out_reg.coef_three;
    assign m_coef_four    = out_reg.coef_four;
    assign m_coef_five    = out_reg.coef_five;
    assign m_solve_status = out_reg.status;

endmodule

// ===== bench/tb_min_jerk_quintic_solver.sv =====
module tb_min_jerk_quintic_solver;

    localparam int FRAC = 16;
    // Pipeline depth plus the two-entry output stage, with margin.
    localparam int DRAIN_CYCLES = mjq_pkg::TOTAL_LAT + 40;

    typedef logic signed [255:0] wide_t;

    // One trajectory request as the sender offers it.
    typedef struct {
        logic signed [mjq_pkg::IN_W-1:0]  x0, v0, a0, x1, v1, a1;
        logic        [mjq_pkg::DUR_W-1:0] dur;
        bit                               drain_first;   // hold until every result is back
    } request_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic signed [mjq_pkg::IN_W-1:0]   s_start_position = '0;
    logic signed [mjq_pkg::IN_W-1:0]   s_start_velocity = '0;
    logic signed [mjq_pkg::IN_W-1:0]   s_start_accel = '0;
    logic signed [mjq_pkg::IN_W-1:0]   s_end_position = '0;
    logic signed [mjq_pkg::IN_W-1:0]   s_end_velocity = '0;
    logic signed [mjq_pkg::IN_W-1:0]   s_end_accel = '0;
    logic        [mjq_pkg::DUR_W-1:0]  s_duration = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [mjq_pkg::COEF_W-1:0] m_coef_zero, m_coef_one, m_coef_two;
    logic signed [mjq_pkg::COEF_W-1:0] m_coef_three, m_coef_four, m_coef_five;
    logic        [1:0]                 m_solve_status;

    request_t      pending_requests[$];
    mjq_pkg::res_t expected_coefs[$];
    request_t      current_request;
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    int            recv_hold = 0;
    bit            hold_done = 1'b0;
    bit            quiet_sender = 1'b0;
    bit            quiet_receiver = 1'b0;

    always #5 aclk = ~aclk;

    min_jerk_quintic_solver #(.INPUT_FRAC_BITS(FRAC)) i_dut (.*);

    // Round |num| * 2^shift / den to nearest, ties away from zero, and clamp
    // to the 48-bit coefficient range. den is always positive here.
    function automatic logic [mjq_pkg::COEF_W-1:0] round_div(input wide_t num,
                                                             input int shift,
                                                             input wide_t den,
                                                             inout bit sat);
        logic [255:0] mag, q, r, limit;
        bit           neg;
        neg   = num[255];
        mag   = neg ? -num : num;
        mag   = mag << shift;
        q     = mag / den;
        r     = mag % den;
        if ((r << 1) >= den) q = q + 1;
        limit = neg ? (256'd1 << 47) : ((256'd1 << 47) - 1);
        if (q > limit) begin
            q   = limit;
            sat = 1'b1;
        end
        return neg ? mjq_pkg::COEF_W'(-q) : mjq_pkg::COEF_W'(q);
    endfunction

    // Closed-form minimum-jerk coefficients for one request.
    function automatic mjq_pkg::res_t solve_quintic(input request_t req);
        mjq_pkg::res_t res;
        wide_t         x0, v0, a0, x1, v1, a1, d, d2;
        wide_t         h0, h1, h2, dh1, d2h2, n3, n4, n5;
        logic [255:0]  amag;
        bit            sat;
        x0 = req.x0; v0 = req.v0; a0 = req.a0;
        x1 = req.x1; v1 = req.v1; a1 = req.a1;
        d  = {232'b0, req.dur};
        sat = 1'b0;
        res.coef_zero = mjq_pkg::COEF_W'(x0 <<< (mjq_pkg::OUT_FRAC - FRAC));
        res.coef_one  = mjq_pkg::COEF_W'(v0 <<< (mjq_pkg::OUT_FRAC - FRAC));
        amag = a0[255] ? -a0 : a0;
        amag = ((amag << (mjq_pkg::OUT_FRAC - FRAC)) + 1) >> 1;
        res.coef_two = a0[255] ? mjq_pkg::COEF_W'(-amag) : mjq_pkg::COEF_W'(amag);
        res.coef_three = '0;
        res.coef_four  = '0;
        res.coef_five  = '0;
        res.status     = mjq_pkg::STATUS_OK;
        if (req.dur == '0) begin
            res.status = mjq_pkg::STATUS_ZERO_DUR;
        end else begin
            // Scaled boundary residuals: h0 by 2^(3F+1), h1 by 2^(2F), h2 by 2^F.
            h0   = ((x1 - x0) <<< (2 * FRAC + 1)) - ((v0 * d) <<< (FRAC + 1)) - a0 * d * d;
            h1   = ((v1 - v0) <<< FRAC) - a0 * d;
            h2   = a1 - a0;
            d2   = d * d;
            dh1  = h1 * d;
            d2h2 = h2 * d2;
            n3 = 10 * h0 - 8 * dh1 + d2h2;
            n4 = 14 * dh1 - 15 * h0 - 2 * d2h2;
            n5 = 6 * h0 - 6 * dh1 + d2h2;
            res.coef_three = round_div(n3, mjq_pkg::OUT_FRAC, 2 * d2 * d, sat);
            res.coef_four  = round_div(n4, mjq_pkg::OUT_FRAC + FRAC, 2 * d2 * d2, sat);
            res.coef_five  = round_div(n5, mjq_pkg::OUT_FRAC + 2 * FRAC, 2 * d2 * d2 * d,
                                       sat);
            if (sat) res.status = mjq_pkg::STATUS_SAT;
        end
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 2));
        return int'($urandom_range(10, 40));
    endfunction

    // Mix full-range values with small ones so both saturated and clean solves occur.
    function automatic logic signed [mjq_pkg::IN_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return mjq_pkg::IN_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return mjq_pkg::IN_W'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return mjq_pkg::IN_W'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    function automatic logic [mjq_pkg::DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return mjq_pkg::DUR_W'($urandom);
            2: return mjq_pkg::DUR_W'($urandom_range(1, 255));
            default: return mjq_pkg::DUR_W'($urandom_range(1 << 14, 1 << 20));
        endcase
    endfunction

    function automatic request_t make_request(input logic signed [mjq_pkg::IN_W-1:0] v,
                                              input logic [mjq_pkg::DUR_W-1:0] dur);
        request_t req;
        req.x0 = v; req.v0 = v; req.a0 = v;
        req.x1 = -v; req.v1 = -v; req.a1 = -v;
        req.dur = dur;
        req.drain_first = 1'b0;
        return req;
    endfunction

    task automatic queue_request(input request_t req);
        pending_requests = {pending_requests, req};
    endtask

    // Sender: advance through the pending requests, idling at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_coefs = {expected_coefs, solve_quintic(current_request)};
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].drain_first &&
                               (expected_coefs.size() > 0 || s_valid))) begin
                    current_request = pending_requests.pop_front();
                    s_start_position <= current_request.x0;
                    s_start_velocity <= current_request.v0;
                    s_start_accel    <= current_request.a0;
                    s_end_position   <= current_request.x1;
                    s_end_velocity   <= current_request.v1;
                    s_end_accel      <= current_request.a1;
                    s_duration       <= current_request.dur;
                    s_valid          <= 1'b1;
                    // keep offering during the long receiver hold so the block fills
                    send_gap = (quiet_sender || recv_hold > 0) ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: one long hold once the run is under way, else random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 300) begin
            hold_done = 1'b1;
            recv_hold = 400;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            recv_gap = quiet_receiver ? 0 : ($urandom_range(0, 3) == 0 ? pick_gap() : 0);
        end
    end

    // Monitor: check each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        mjq_pkg::res_t exp_res;
        bit            bad;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_coefs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction, status %0d", m_solve_status);
            end else begin
                exp_res = expected_coefs.pop_front();
                bad = (m_coef_zero !== exp_res.coef_zero) ||
                      (m_coef_one !== exp_res.coef_one) ||
                      (m_coef_two !== exp_res.coef_two) ||
                      (m_coef_three !== exp_res.coef_three) ||
                      (m_coef_four !== exp_res.coef_four) ||
                      (m_coef_five !== exp_res.coef_five) ||
                      (m_solve_status !== exp_res.status);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at result %0d", results_seen);
                        $display("  exp c0..c2 %h %h %h", exp_res.coef_zero,
                                 exp_res.coef_one, exp_res.coef_two);
                        $display("  got c0..c2 %h %h %h", m_coef_zero, m_coef_one,
                                 m_coef_two);
                        $display("  exp c3..c5 %h %h %h st %0d", exp_res.coef_three,
                                 exp_res.coef_four, exp_res.coef_five, exp_res.status);
                        $display("  got c3..c5 %h %h %h st %0d", m_coef_three,
                                 m_coef_four, m_coef_five, m_solve_status);
                    end
                end
            end
        end
    end

    initial begin
        request_t req;
        int       settle;
        // Directed requests: field extremes, zero and extreme durations, one-LSB values.
        queue_request(make_request(32'sh7FFFFFFF, 24'hFFFFFF));
        queue_request(make_request(32'sh80000000, 24'hFFFFFF));
        queue_request(make_request(32'sh7FFFFFFF, 24'd1));
        queue_request(make_request(32'sh80000000, 24'd1));
        queue_request(make_request(32'sh7FFFFFFF, 24'd0));
        queue_request(make_request(32'sh80000000, 24'd0));
        queue_request(make_request(32'sh0, 24'd0));
        queue_request(make_request(32'sh0, 24'h010000));
        queue_request(make_request(-32'sd1, 24'h010000));   // negative one-LSB value, halved exactly on c2
        queue_request(make_request(32'sd1, 24'h010000));    // positive one-LSB value, halved exactly on c2
        queue_request(make_request(32'sh00010000, 24'h020000));
        queue_request(make_request(-32'sh00018000, 24'h008000));
        queue_request(make_request(32'sh55555555, 24'h800000));
        queue_request(make_request(32'shAAAAAAAA, 24'h7FFFFF));
        // Rest to rest move of one unit in one second: a clean, unsaturated solve.
        req = make_request(32'sh0, 24'h010000);
        req.x1 = 32'sh00010000; req.v1 = '0; req.a1 = '0;
        queue_request(req);
        req.x0 = 32'sh7FFFFFFF; req.x1 = 32'sh80000000; req.dur = 24'd2;
        queue_request(req);

        for (int i = 0; i < 1250; i++) begin
            req.x0 = pick_value(); req.v0 = pick_value(); req.a0 = pick_value();
            req.x1 = pick_value(); req.v1 = pick_value(); req.a1 = pick_value();
            req.dur = pick_duration();
            // Sender pauses here until the block has returned every result.
            req.drain_first = (i == 700);
            queue_request(req);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Alternate stretches with and without idling on both sides.
        while (pending_requests.size() > 0) begin
            quiet_sender   = ($urandom_range(0, 3) == 0);
            quiet_receiver = ($urandom_range(0, 3) == 0);
            repeat (200) @(posedge aclk);
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        while (s_valid) @(posedge aclk);
        while (expected_coefs.size() > 0) @(posedge aclk);
        settle = DRAIN_CYCLES;
        repeat (settle) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
